>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define CPT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When pre holds at one edge, post must hold at the next edge.
`define CPT_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define CPT_ASSERT(name, prop, msg)
`define CPT_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

>>> hw/rtl/cptab_pkg.sv
// ---------------------------------------------------------------------------
// cptab_pkg
// Types and constants shared by the checkpoint table modules.
// ---------------------------------------------------------------------------
package cptab_pkg;

  localparam int unsigned LINE_BITS = 31;

  // Spacing never grows past 2^14 lines.
  localparam logic [3:0] MAX_SPACING_EXP = 4'd14;

  typedef enum logic [1:0] {
    CMD_FIT    = 2'd0,
    CMD_DIRTY  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_RECORD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIT_CHECK,
    S_FIT_COPY
  } state_t;

  // Re-initialization request from the capacity register.
  typedef struct packed {
    logic wr;
    logic nonempty;
  } init_t;

  // One result item.
  typedef struct packed {
    logic [7:0]           found_state;
    logic [LINE_BITS-1:0] start_line;
    logic [3:0]           spacing_log2;
    logic [8:0]           valid_count;
  } res_t;

endpackage

>>> hw/rtl/cptab_mem.sv
// ---------------------------------------------------------------------------
// cptab_mem
// Slot store: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module cptab_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data only moves when a read is issued, so it stays put while a
  // result waits on the output side.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/cptab_ctrl.sv
// ---------------------------------------------------------------------------
// cptab_ctrl
// Command sequencer: issues slot reads and writes, walks fit compaction
// passes and keeps the spacing exponent and the valid prefix length.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cptab_ctrl import cptab_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int STATE_BITS = 8,
  localparam int AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  init_t                    init,
  input  logic [8:0]               capacity,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               cmd,
  input  logic signed [31:0]       line,
  input  logic [7:0]               new_state,
  output logic                     res_valid,
  input  logic                     res_ready,
  output res_t                     res,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic [STATE_BITS-1:0]    mem_wdata,
  output logic                     mem_re,
  output logic [AW-1:0]            mem_raddr,
  input  logic [STATE_BITS-1:0]    mem_rdata
);

  localparam int NB = (STATE_BITS < 8) ? STATE_BITS : 8;

  state_t               state, state_next;
  cmd_t                 cmd_q;
  logic [LINE_BITS-1:0] line_q;
  logic                 neg_q;
  logic [7:0]           nst_q;
  logic [8:0]           look_idx;
  logic [3:0]           spacing, spacing_next;
  logic [8:0]           valid_slots, valid_next;
  logic                 zero0, zero0_next;
  logic                 rd_zero;
  logic [8:0]           k, k_next;

  logic [LINE_BITS-1:0] line_in_c;
  logic [LINE_BITS-1:0] sh_in;
  logic [8:0]           look_idx_in;
  logic [LINE_BITS-1:0] sh_q;
  logic [LINE_BITS-1:0] low_mask;
  logic [31:0]          keep;
  logic                 rec_ok;
  logic                 rec_hit;
  logic [8:0]           rec_idx;
  logic                 fit_go;
  logic [8:0]           pairs;
  logic [8:0]           k_inc;
  logic [STATE_BITS-1:0] slot_val;

  // Input side: clamp the line and pick the lookup slot so the read can
  // go out in the transfer cycle.
  assign line_in_c   = line[31] ? '0 : line[30:0];
  assign sh_in       = line_in_c >> spacing;
  assign look_idx_in = ({22'b0, valid_slots} > sh_in) ? sh_in[8:0] : valid_slots - 9'd1;

  // Held item side.
  assign sh_q     = line_q >> spacing;
  assign low_mask = ~({LINE_BITS{1'b1}} << spacing);
  assign keep     = {1'b0, sh_q} + 32'd1;
  assign rec_idx  = sh_q[8:0];
  assign rec_ok   = !neg_q && ((line_q & low_mask) == '0) && (sh_q < {22'b0, capacity});
  assign rec_hit  = rec_ok && (rec_idx <= valid_slots);
  assign fit_go   = (capacity != 9'd0) && ({22'b0, capacity} <= sh_q) &&
                    (spacing < MAX_SPACING_EXP);
  assign pairs    = 9'((10'(valid_slots) + 10'd1) >> 1);
  assign k_inc    = k + 9'd1;
  assign slot_val = rd_zero ? '0 : mem_rdata;

  always_comb begin
    state_next   = state;
    spacing_next = spacing;
    valid_next   = valid_slots;
    zero0_next   = zero0;
    k_next       = k;
    in_stall     = 1'b1;
    res_valid    = 1'b0;
    res          = '0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(look_idx_in);
          state_next = (cmd_t'(cmd) == CMD_FIT) ? S_FIT_CHECK : S_EXEC;
        end
      end

      S_FIT_CHECK: begin
        if (fit_go) begin
          if (pairs != 9'd0) begin
            mem_re     = 1'b1;
            mem_raddr  = '0;
            k_next     = 9'd0;
            state_next = S_FIT_COPY;
          end else begin
            spacing_next = spacing + 4'd1;
          end
        end else begin
          state_next = S_EXEC;
        end
      end

      S_FIT_COPY: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(k);
        mem_wdata = slot_val;
        if (k == 9'd0) begin
          zero0_next = 1'b0;
        end
        if (k_inc < pairs) begin
          mem_re    = 1'b1;
          mem_raddr = AW'({k_inc[7:0], 1'b0});
          k_next    = k_inc;
        end else begin
          valid_next   = pairs;
          spacing_next = spacing + 4'd1;
          state_next   = S_FIT_CHECK;
        end
      end

      S_EXEC: begin
        res_valid = 1'b1;
        unique case (cmd_q)
          CMD_DIRTY: begin
            if ({23'b0, valid_slots} > keep) begin
              valid_next = keep[8:0];
            end
          end
          CMD_LOOKUP: begin
            if (valid_slots != 9'd0) begin
              res.found_state = 8'(slot_val[NB-1:0]);
              res.start_line  = LINE_BITS'(look_idx) << spacing;
            end
          end
          CMD_RECORD: begin
            if (rec_hit) begin
              mem_we    = res_ready;
              mem_waddr = AW'(rec_idx);
              mem_wdata = STATE_BITS'(nst_q[NB-1:0]);
              if (rec_idx == 9'd0) begin
                zero0_next = 1'b0;
              end
              if (rec_idx == valid_slots) begin
                valid_next = valid_slots + 9'd1;
              end
            end
          end
          CMD_FIT: begin
          end
        endcase
        res.spacing_log2 = spacing;
        res.valid_count  = valid_next;
        if (res_ready) begin
          state_next = S_IDLE;
        end else begin
          valid_next = valid_slots;
          zero0_next = zero0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      spacing     <= 4'd0;
      valid_slots <= 9'd1;
      zero0       <= 1'b1;
      k           <= 9'd0;
    end else if (init.wr) begin
      state       <= state_next;
      spacing     <= 4'd0;
      valid_slots <= init.nonempty ? 9'd1 : 9'd0;
      zero0       <= 1'b1;
      k           <= k_next;
    end else begin
      state       <= state_next;
      spacing     <= spacing_next;
      valid_slots <= valid_next;
      zero0       <= zero0_next;
      k           <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_q    <= cmd_t'(cmd);
      line_q   <= line_in_c;
      neg_q    <= line[31];
      nst_q    <= new_state;
      look_idx <= look_idx_in;
    end
    if (mem_re) begin
      rd_zero <= (mem_raddr == '0) && zero0;
    end
  end

  `CPT_ASSERT(a_valid_within_cap, valid_slots <= capacity, "valid prefix exceeds capacity")
  `CPT_ASSERT(a_spacing_limit, spacing <= MAX_SPACING_EXP, "spacing exponent past limit")
  `CPT_ASSERT(a_copy_in_prefix, (state == S_FIT_COPY) |-> (k < valid_slots), "compaction write outside valid prefix")
  `CPT_ASSERT_NEXT(a_exec_waits, (state == S_EXEC) && !res_ready && !init.wr, state == S_EXEC, "result dropped while output busy")

endmodule

>>> hw/rtl/decimating_checkpoint_table.sv
// ---------------------------------------------------------------------------
// decimating_checkpoint_table: sparse lexer-state checkpoint table.
// Dirty, lookup, record: exec state after transfer, result registered; one item at a time.
// Fit: per doubling pass, a check state, then ceil(valid/2) slot copies (one read port).
// Synchronous rst: spacing 0, one valid slot reading as the normal state, capacity min(CAPACITY, 256).
// ---------------------------------------------------------------------------
module decimating_checkpoint_table import cptab_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int STATE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [8:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] line,
  input  logic [7:0]         new_state,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         found_state,
  output logic [30:0]        start_line,
  output logic [3:0]         spacing_log2,
  output logic [8:0]         valid_count
);

  // Address width of the slot store. Only slots below the capacity register
  // are ever written, and that register never exceeds CAPACITY.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Capacity after reset, and the ceiling that a write is clamped to.
  localparam logic [8:0] CAP_RESET = 9'((CAPACITY < 256) ? CAPACITY : 256);
  localparam logic [8:0] CAP_MAX   = 9'((CAPACITY < 511) ? CAPACITY : 511);

  logic [8:0]            capacity;
  logic [8:0]            cap_in;
  init_t                 init;
  res_t                  res;
  logic                  res_valid;
  logic                  res_ready;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [STATE_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [STATE_BITS-1:0] mem_rdata;

  // A capacity write above the table's physical size is taken as that size.
  // Every write re-initializes the table, which the sequencer handles.
  assign cap_in        = ({23'b0, cfg_wr_data} > 32'(CAPACITY)) ? CAP_MAX : cfg_wr_data;
  assign init.wr       = cfg_wr_en;
  assign init.nonempty = (cap_in != 9'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cap_in;
    end
  end

  // The output register separates the two sides: the sequencer can take the
  // next transfer while a finished result still sits here. Dirty and record
  // commit their state changes only in the cycle that the result moves into
  // this register; a fit commits its compaction passes before then.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      found_state  <= res.found_state;
      start_line   <= res.start_line;
      spacing_log2 <= res.spacing_log2;
      valid_count  <= res.valid_count;
    end
  end

  // Sequencer: decodes commands, walks compaction passes and owns the
  // spacing exponent and the valid prefix length.
  cptab_ctrl #(
    .CAPACITY   (CAPACITY),
    .STATE_BITS (STATE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .init      (init),
    .capacity  (capacity),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .line      (line),
    .new_state (new_state),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Slot store. Data read from outside the valid prefix is never used, so the
  // array itself needs no clearing; slot zero's normal state after reset is
  // supplied by the sequencer until that slot is first written.
  cptab_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (STATE_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

>>> sim/checkpoint_table_checker.sv
// ---------------------------------------------------------------------------
// checkpoint_table_checker
// Watches both channels of the checkpoint table and the capacity port. It
// predicts each result from its own copy of the table and compares fields.
// ---------------------------------------------------------------------------
module checkpoint_table_checker import cptab_pkg::*; #(
  parameter int unsigned SLOTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [8:0]         cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] line,
  input  logic [7:0]         new_state,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         found_state,
  input  logic [30:0]        start_line,
  input  logic [3:0]         spacing_log2,
  input  logic [8:0]         valid_count,
  output int                 error_count,
  output int                 result_count,
  output int                 expected_left,
  output logic [3:0]         hint_spacing,
  output logic [8:0]         hint_valid
);

  // Shadow copy of the table.
  logic [7:0]  slot_mem [SLOTS];
  logic [3:0]  grid_exp;
  int unsigned live_slots;
  int unsigned cap_slots;

  res_t pending_results [$];
  int   mismatches;
  int   delivered;

  task automatic init_table(input int unsigned cap);
    cap_slots  = cap;
    grid_exp   = '0;
    live_slots = (cap > 0) ? 1 : 0;
    slot_mem[0] = '0;
  endtask

  task automatic apply_command(input cmd_t op, input logic [31:0] raw,
                               input logic [7:0] st, output res_t r);
    logic [31:0] pos;
    int unsigned idx;
    int unsigned keep;
    pos = raw[31] ? 32'd0 : raw;
    r = '0;
    case (op)
      CMD_FIT: begin
        // Halve the table until the line count fits or the spacing tops out.
        if (cap_slots > 0) begin
          while ((pos >> grid_exp) >= cap_slots && grid_exp < MAX_SPACING_EXP) begin
            for (int unsigned i = 0; 2 * i < live_slots && 2 * i < SLOTS; i++)
              slot_mem[i] = slot_mem[2 * i];
            live_slots = (live_slots + 1) / 2;
            grid_exp++;
          end
        end
      end
      CMD_DIRTY: begin
        keep = (pos >> grid_exp) + 1;
        if (live_slots > keep) live_slots = keep;
      end
      CMD_LOOKUP: begin
        if (live_slots > 0) begin
          idx = pos >> grid_exp;
          if (idx >= live_slots) idx = live_slots - 1;
          r.found_state = slot_mem[idx];
          r.start_line  = 31'(idx << grid_exp);
        end
      end
      default: begin
        // Record only on the grid, inside capacity, and no further than one
        // slot past the valid prefix.
        if (!raw[31] && (raw & ((32'd1 << grid_exp) - 32'd1)) == 32'd0) begin
          idx = raw >> grid_exp;
          if (idx < cap_slots && idx < SLOTS) begin
            if (idx < live_slots) begin
              slot_mem[idx] = st;
            end else if (idx == live_slots) begin
              slot_mem[idx] = st;
              live_slots = idx + 1;
            end
          end
        end
      end
    endcase
    r.spacing_log2 = grid_exp;
    r.valid_count  = live_slots[8:0];
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t predicted;
    res_t oldest;
    if (rst) begin
      init_table(SLOTS);
      pending_results.delete();
      mismatches = 0;
      delivered  = 0;
    end else begin
      if (cfg_wr_en)
        init_table((cfg_wr_data > SLOTS) ? SLOTS : cfg_wr_data);
      // Retire a result before queuing a new prediction; a result can never
      // belong to an item accepted at the same edge.
      if (out_valid && !out_stall) begin
        delivered++;
        if (pending_results.size() == 0) begin
          $error("result with no prediction waiting: found_state %0d, start_line %0d",
                 found_state, start_line);
          mismatches++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("found_state", 32'(oldest.found_state), 32'(found_state));
          check_field("start_line", 32'(oldest.start_line), 32'(start_line));
          check_field("spacing_log2", 32'(oldest.spacing_log2), 32'(spacing_log2));
          check_field("valid_count", 32'(oldest.valid_count), 32'(valid_count));
        end
      end
      if (in_valid && !in_stall) begin
        apply_command(cmd_t'(cmd), line, new_state, predicted);
        pending_results.push_back(predicted);
      end
    end
    error_count   <= mismatches;
    result_count  <= delivered;
    expected_left <= pending_results.size();
    hint_spacing  <= grid_exp;
    hint_valid    <= live_slots[8:0];
  end

endmodule

>>> sim/tb_decimating_checkpoint_table.sv
// ---------------------------------------------------------------------------
// tb_decimating_checkpoint_table
// Drives directed and random commands into the checkpoint table under random
// idling on both channels, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_decimating_checkpoint_table;
  import cptab_pkg::*;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 100;
  // The slowest fit is 14 halving passes over up to 256 slots; this limit
  // leaves a wide margin over any run of this stimulus.
  localparam int CYCLE_LIMIT     = 2_000_000;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_wr_en   = 1'b0;
  logic [8:0]         cfg_wr_data = '0;
  logic               in_valid    = 1'b0;
  logic [1:0]         cmd         = CMD_LOOKUP;
  logic signed [31:0] line        = '0;
  logic [7:0]         new_state   = '0;
  logic               out_stall   = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [7:0]  found_state;
  logic [30:0] start_line;
  logic [3:0]  spacing_log2;
  logic [8:0]  valid_count;

  int         error_count;
  int         result_count;
  int         expected_left;
  logic [3:0] hint_spacing;
  logic [8:0] hint_valid;

  int items_sent = 0;
  int cycles     = 0;
  int stall_left = 0;
  // Enables random idling on both channels; it is turned off for the last
  // phase so that the tail of the run goes back to back.
  bit idle_on    = 1'b1;

  decimating_checkpoint_table dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .line         (line),
    .new_state    (new_state),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found_state  (found_state),
    .start_line   (start_line),
    .spacing_log2 (spacing_log2),
    .valid_count  (valid_count)
  );

  checkpoint_table_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .line          (line),
    .new_state     (new_state),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found_state   (found_state),
    .start_line    (start_line),
    .spacing_log2  (spacing_log2),
    .valid_count   (valid_count),
    .error_count   (error_count),
    .result_count  (result_count),
    .expected_left (expected_left),
    .hint_spacing  (hint_spacing),
    .hint_valid    (hint_valid)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_decimating_checkpoint_table: errors");
      $finish;
    end
  end

  // The result side stalls in random bursts. A burst starts with a fixed
  // chance on any free cycle, so stalls land on every phase of the block's
  // work, including the middle of a fit compaction.
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one command and hold it until its transfer. When idling is on, a
  // random gap may come first; valid is only lowered in a step where it is
  // not raised again.
  task automatic send_item(input cmd_t op, input logic [31:0] pos, input logic [7:0] st);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    line      <= pos;
    new_state <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // The capacity register is only written once every result has been
  // delivered, so the block is idle. Each write re-initializes the table.
  task automatic write_capacity(input logic [8:0] value);
    in_valid <= 1'b0;
    while (result_count != items_sent) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random command. Most are well formed: records on the grid that append or
  // overwrite, and lookups, truncations and fits near the live part of the
  // table. The checker's view of spacing and fill steers these; it may lag by
  // one item, which only turns an append into an overwrite now and then. The
  // rest is noise over the whole line range, negatives included.
  task automatic random_item();
    int unsigned pick;
    int unsigned idx;
    int unsigned span;
    logic [31:0] pos;
    cmd_t        op;
    pick = $urandom_range(0, 99);
    op   = cmd_t'($urandom_range(0, 3));
    pos  = $urandom;
    span = (int'(hint_valid) + 2) << hint_spacing;
    if (pick < 45) begin
      op = CMD_RECORD;
      if ($urandom_range(0, 3) != 0)
        idx = int'(hint_valid) + $urandom_range(0, 1);
      else
        idx = $urandom_range(0, int'(hint_valid));
      pos = idx << hint_spacing;
    end else if (pick < 65) begin
      op  = CMD_LOOKUP;
      pos = $urandom_range(0, span);
    end else if (pick < 75) begin
      op  = CMD_DIRTY;
      pos = $urandom_range(0, span);
    end else if (pick < 85) begin
      op  = CMD_FIT;
      pos = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4 * span);
    end
    send_item(op, pos, 8'($urandom));
  endtask

  initial begin : stimulus
    int unsigned cap;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting from the reset table at full capacity.
    send_item(CMD_LOOKUP, 32'd0, 8'h00);
    send_item(CMD_LOOKUP, 32'h8000_0000, 8'hFF);   // negative line clamps to zero
    send_item(CMD_RECORD, 32'd0, 8'hFF);
    send_item(CMD_RECORD, 32'd1, 8'hA5);           // append
    send_item(CMD_RECORD, 32'd3, 8'h11);           // past the append point
    send_item(CMD_RECORD, 32'hFFFF_FFFF, 8'h22);   // negative record is dropped
    send_item(CMD_RECORD, 32'd2, 8'h5A);
    send_item(CMD_LOOKUP, 32'h7FFF_FFFF, 8'h00);   // past the prefix: last slot
    send_item(CMD_DIRTY, 32'd1, 8'h00);
    send_item(CMD_DIRTY, 32'h8000_0000, 8'h00);
    send_item(CMD_FIT, 32'd255, 8'h00);            // already fits
    send_item(CMD_FIT, 32'h7FFF_FFFF, 8'h00);      // stops at the spacing limit
    send_item(CMD_RECORD, 32'd1, 8'h33);           // off the grid
    send_item(CMD_RECORD, 32'd16384, 8'hC3);
    send_item(CMD_LOOKUP, 32'd20000, 8'h00);
    send_item(CMD_RECORD, 32'h0040_0000, 8'h44);   // slot index at capacity
    send_item(CMD_FIT, 32'd0, 8'h00);

    // Zero capacity: nothing is stored and lookups see an empty table.
    write_capacity(9'd0);
    send_item(CMD_LOOKUP, 32'd5, 8'h00);
    send_item(CMD_FIT, 32'd1000, 8'h00);
    send_item(CMD_RECORD, 32'd0, 8'h66);
    send_item(CMD_DIRTY, 32'd7, 8'h00);

    // A single slot.
    write_capacity(9'd1);
    send_item(CMD_RECORD, 32'd1, 8'h77);
    send_item(CMD_RECORD, 32'd0, 8'h7E);
    send_item(CMD_FIT, 32'd100, 8'h00);
    send_item(CMD_LOOKUP, 32'h7FFF_FFFF, 8'h00);

    // Random phases, each under its own capacity. All ones clamps to full.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       cap = 9'h1FF;
        1:       cap = $urandom_range(2, 16);
        2:       cap = 1;
        3:       cap = $urandom_range(0, 511);
        4:       cap = $urandom_range(17, 256);
        default: cap = $urandom_range(2, 64);
      endcase
      idle_on <= (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
      write_capacity(cap[8:0]);
      repeat (ITEMS_PER_PHASE) random_item();
    end

    in_valid <= 1'b0;
    while (result_count != items_sent) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0 && expected_left == 0) begin
      $display("tb_decimating_checkpoint_table: clean");
    end else begin
      $display("tb_decimating_checkpoint_table: errors");
    end
    $finish;
  end

endmodule

>>> decimating_checkpoint_table.f
+incdir+hw/rtl
hw/rtl/cptab_pkg.sv
hw/rtl/cptab_mem.sv
hw/rtl/cptab_ctrl.sv
hw/rtl/decimating_checkpoint_table.sv
sim/checkpoint_table_checker.sv
sim/tb_decimating_checkpoint_table.sv
